FILE: sv/kvh_pkg.sv
// ----------------------------------------------------------------------------
// kvh_pkg
// Shared types and constants of the key/value hash table: request codes,
// field widths and the control/status words between controller and datapath.
// ----------------------------------------------------------------------------
package kvh_pkg;

  localparam int TYPE_W  = 2;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 7;

  localparam logic [TYPE_W-1:0] REQ_GET    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_PUT    = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_req;   // capture request word, start set index
    logic mem_rd;     // read the set row
    logic clr_step;   // write one zero row of the clearing pass
    logic commit;     // write back the row and load the result word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/kvh_req_if.sv
// ----------------------------------------------------------------------------
// kvh_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface kvh_req_if;
  import kvh_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_value;

  modport source (output valid, output req_type, output req_key, output req_value,
                  input ready);
  modport sink   (input valid, input req_type, input req_key, input req_value,
                  output ready);
endinterface

FILE: sv/kvh_rsp_if.sv
// ----------------------------------------------------------------------------
// kvh_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface kvh_rsp_if;
  import kvh_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic               accepted;
  logic [KEY_W-1:0]   key_out;
  logic [VAL_W-1:0]   value_out;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output found, output accepted, output key_out,
                  output value_out, output entry_count, input ready);
  modport sink   (input valid, input found, input accepted, input key_out,
                  input value_out, input entry_count, output ready);
endinterface

FILE: sv/kvh_set_index.sv
// ----------------------------------------------------------------------------
// kvh_set_index
// Set index of a key: key modulo NUM_SETS. A mask for a power of two,
// otherwise a radix-16 remainder unit, one nibble per cycle.
// ----------------------------------------------------------------------------
module kvh_set_index #(
  parameter int NUM_SETS = 16,
  parameter int SET_W    = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [kvh_pkg::KEY_W-1:0] key,
  output logic                     done,
  output logic [SET_W-1:0]         set_idx
);
  import kvh_pkg::*;

  if ((NUM_SETS & (NUM_SETS - 1)) == 0) begin : g_mask
    logic             done_r;
    logic [SET_W-1:0] idx_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        idx_r <= key[SET_W-1:0] & SET_W'(NUM_SETS - 1);
      end
    end

    assign done    = done_r;
    assign set_idx = idx_r;

  end else begin : g_serial
    localparam int V_W    = SET_W + 4;
    localparam int DIGITS = KEY_W / 4;
    localparam int DIG_W  = $clog2(DIGITS);

    logic             busy_r;
    logic             done_r;
    logic [DIG_W-1:0] dig_r;
    logic [KEY_W-1:0] key_sh_r;
    logic [SET_W-1:0] rem_r;
    logic [V_W-1:0]   v;
    logic [V_W-1:0]   sub;
    logic [SET_W-1:0] rem_nxt;

    // next partial remainder: 16*rem + nibble, minus the largest fitting k*N
    always_comb begin
      v   = {rem_r, key_sh_r[KEY_W-1 -: 4]};
      sub = '0;
      for (int k = 1; k < 16; k++) begin
        if (v >= V_W'(k * NUM_SETS)) begin
          sub = V_W'(k * NUM_SETS);
        end
      end
      rem_nxt = SET_W'(v - sub);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
        dig_r  <= '0;
      end else begin
        done_r <= 1'b0;
        if (start) begin
          busy_r <= 1'b1;
          dig_r  <= '0;
        end else if (busy_r) begin
          dig_r <= dig_r + DIG_W'(1);
          if (dig_r == DIG_W'(DIGITS - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        key_sh_r <= key;
        rem_r    <= '0;
      end else if (busy_r) begin
        key_sh_r <= {key_sh_r[KEY_W-5:0], 4'b0};
        rem_r    <= rem_nxt;
      end
    end

    assign done    = done_r;
    assign set_idx = rem_r;
  end

endmodule

FILE: sv/kvh_datapath.sv
// ----------------------------------------------------------------------------
// kvh_datapath
// Request register, set index unit, set-row memory, parallel way compare,
// entry counter and result register.
// ----------------------------------------------------------------------------
module kvh_datapath #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kvh_pkg::cmd_t               cmd,
  output kvh_pkg::sts_t               sts,
  input  logic [kvh_pkg::TYPE_W-1:0]  req_type,
  input  logic [kvh_pkg::KEY_W-1:0]   req_key,
  input  logic [kvh_pkg::VAL_W-1:0]   req_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic                        accepted,
  output logic [kvh_pkg::KEY_W-1:0]   key_out,
  output logic [kvh_pkg::VAL_W-1:0]   value_out,
  output logic [kvh_pkg::COUNT_W-1:0] entry_count
);
  import kvh_pkg::*;

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int CNT_W = $clog2(NUM_SETS * NUM_WAYS + 1);

  logic [TYPE_W-1:0] type_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  value_r;

  logic             hash_done;
  logic [SET_W-1:0] set_idx;
  logic [SET_W-1:0] clr_addr_r;

  // set-row memory
  logic [NUM_WAYS-1:0]            vld_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][KEY_W-1:0] key_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][VAL_W-1:0] val_mem [NUM_SETS];

  logic [NUM_WAYS-1:0]            rd_vld_r;
  logic [NUM_WAYS-1:0][KEY_W-1:0] rd_key_r;
  logic [NUM_WAYS-1:0][VAL_W-1:0] rd_val_r;

  logic [NUM_WAYS-1:0]            wr_vld;
  logic [NUM_WAYS-1:0][KEY_W-1:0] wr_key;
  logic [NUM_WAYS-1:0][VAL_W-1:0] wr_val;
  logic                           wr_en;
  logic [SET_W-1:0]               wr_addr;

  logic [NUM_WAYS-1:0]            new_vld;
  logic [NUM_WAYS-1:0][KEY_W-1:0] new_key;
  logic [NUM_WAYS-1:0][VAL_W-1:0] new_val;

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             free;
  logic [WAY_W-1:0] free_way;

  logic             found_nxt;
  logic             accepted_nxt;
  logic [KEY_W-1:0] kout_nxt;
  logic [VAL_W-1:0] vout_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  logic               out_valid_r;
  logic               found_r;
  logic               accepted_r;
  logic [KEY_W-1:0]   key_out_r;
  logic [VAL_W-1:0]   value_out_r;
  logic [COUNT_W-1:0] count_out_r;

  kvh_set_index #(
    .NUM_SETS (NUM_SETS),
    .SET_W    (SET_W)
  ) u_set_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.load_req),
    .key     (req_key),
    .done    (hash_done),
    .set_idx (set_idx)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      type_r  <= req_type;
      key_r   <= req_key;
      value_r <= req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + SET_W'(1);
    end
  end

  assign wr_en   = cmd.clr_step | cmd.commit;
  assign wr_addr = cmd.clr_step ? clr_addr_r : set_idx;
  assign wr_vld  = cmd.clr_step ? '0 : new_vld;
  assign wr_key  = cmd.clr_step ? '0 : new_key;
  assign wr_val  = cmd.clr_step ? '0 : new_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vld_mem[wr_addr] <= wr_vld;
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (cmd.mem_rd) begin
      rd_vld_r <= vld_mem[set_idx];
      rd_key_r <= key_mem[set_idx];
      rd_val_r <= val_mem[set_idx];
    end
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_vld_r[w]) begin
        if (rd_key_r[w] == key_r) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    new_vld      = rd_vld_r;
    new_key      = rd_key_r;
    new_val      = rd_val_r;
    found_nxt    = 1'b0;
    accepted_nxt = 1'b0;
    kout_nxt     = '0;
    vout_nxt     = '0;
    cnt_nxt      = cnt_r;
    case (type_r)
      REQ_GET: begin
        if (hit) begin
          found_nxt = 1'b1;
          vout_nxt  = rd_val_r[hit_way];
        end
      end
      REQ_PUT: begin
        if (hit) begin
          found_nxt        = 1'b1;
          accepted_nxt     = 1'b1;
          new_val[hit_way] = value_r;
        end else if (free) begin
          accepted_nxt      = 1'b1;
          new_vld[free_way] = 1'b1;
          new_key[free_way] = key_r;
          new_val[free_way] = value_r;
          cnt_nxt           = cnt_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (hit) begin
          found_nxt        = 1'b1;
          kout_nxt         = rd_key_r[hit_way];
          vout_nxt         = rd_val_r[hit_way];
          new_vld[hit_way] = 1'b0;
          new_key[hit_way] = '0;
          new_val[hit_way] = '0;
          cnt_nxt          = cnt_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found_r     <= found_nxt;
      accepted_r  <= accepted_nxt;
      key_out_r   <= kout_nxt;
      value_out_r <= vout_nxt;
      count_out_r <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign sts.hash_done = hash_done;
  assign sts.clr_last  = (clr_addr_r == SET_W'(NUM_SETS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign found       = found_r;
  assign accepted    = accepted_r;
  assign key_out     = key_out_r;
  assign value_out   = value_out_r;
  assign entry_count = count_out_r;

endmodule

FILE: sv/kvh_ctrl.sv
// ----------------------------------------------------------------------------
// kvh_ctrl
// Request sequencer: clearing pass after reset, then per request accept,
// set index, row read and compare/write back.
// ----------------------------------------------------------------------------
module kvh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output kvh_pkg::cmd_t cmd,
  input  kvh_pkg::sts_t sts
);
  import kvh_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_HASH  = 2'd2;
  localparam logic [1:0] S_LOOK  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load_req = 1'b0;
    cmd.mem_rd   = 1'b0;
    cmd.clr_step = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
        if (in_valid) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.mem_rd = sts.hash_done;
        if (sts.hash_done) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        // hold the row until the result register can take a word
        cmd.commit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/key_value_hash_table_top.sv
// ----------------------------------------------------------------------------
// key_value_hash_table_top
// Set-associative map from 64-bit keys to 32-bit values with get, put and
// remove requests; one result word per request.
//
//   channel  dir  handshake     payload
//   in_req   in   valid/ready   req_type, req_key, req_value
//   out_rsp  out  valid/ready   found, accepted, key_out, value_out, entry_count
//
// A request passes through accept, set-row read and compare and write back; when
// NUM_SETS is not a power of two the set index between accept and read
// comes from a radix-16 remainder unit working one nibble per cycle.
// After reset a clearing pass writes NUM_SETS zero rows, one per cycle,
// before the first request is taken.
// The result register frees the request side; a stalled result holds the
// next request in its compare step until the word is taken.
// ----------------------------------------------------------------------------
module key_value_hash_table_top #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  kvh_req_if.sink   in_req,
  kvh_rsp_if.source out_rsp
);
  import kvh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kvh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  kvh_datapath #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (in_req.req_type),
    .req_key     (in_req.req_key),
    .req_value   (in_req.req_value),
    .out_valid   (out_rsp.valid),
    .out_ready   (out_rsp.ready),
    .found       (out_rsp.found),
    .accepted    (out_rsp.accepted),
    .key_out     (out_rsp.key_out),
    .value_out   (out_rsp.value_out),
    .entry_count (out_rsp.entry_count)
  );

endmodule

FILE: bench/key_value_hash_table_top_tb.sv
// ----------------------------------------------------------------------------
// key_value_hash_table_top_tb
// Drives get, put and remove words into the hash table through its request
// channel and checks every result word against a set-associative predictor
// kept alongside it. A directed opening covers empty, full and replacing
// cases, then random phases fill and drain the store over a small key pool.
// ----------------------------------------------------------------------------
module key_value_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvh_pkg::*;

  localparam int NUM_SETS         = 16;
  localparam int NUM_WAYS         = 4;
  localparam int STORE_SIZE       = NUM_SETS * NUM_WAYS;
  localparam int POOL_SIZE        = 80;
  localparam int SEGMENTS         = 13;
  localparam int SEGMENT_LEN      = 150;
  localparam int LONG_HOLD_AT     = 900;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 12;
  localparam int CYCLE_LIMIT      = 600000;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  localparam int PROFILE_FILL  = 0;
  localparam int PROFILE_MIXED = 1;
  localparam int PROFILE_DRAIN = 2;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              wait_idle;
  } req_word_t;

  typedef struct packed {
    logic               found;
    logic               accepted;
    logic [KEY_W-1:0]   key_out;
    logic [VAL_W-1:0]   value_out;
    logic [COUNT_W-1:0] entry_count;
  } rsp_word_t;

  logic clk;
  logic rst_n;

  kvh_req_if req_bus();
  kvh_rsp_if rsp_bus();

  key_value_hash_table_top #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  // shadow store
  logic             slot_valid [STORE_SIZE];
  logic [KEY_W-1:0] slot_key   [STORE_SIZE];
  logic [VAL_W-1:0] slot_value [STORE_SIZE];
  int               live_count;

  req_word_t   pending_q[$];
  rsp_word_t   expected_q[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int   mismatches;
  int   words_queued;
  int   words_taken;
  int   cycle_count;
  int   send_gap;
  int   stall_left;
  logic req_taken;
  logic long_hold_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // quiet stretches with no idling on either side
  function automatic logic calm_phase();
    return ((words_taken / 200) % 3) == 1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase() || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic rsp_word_t apply_request(req_word_t rq);
    rsp_word_t r;
    int base, hit, free_way, idx;
    r = '0;
    hit = -1;
    free_way = -1;
    base = int'(rq.key % 64'(NUM_SETS)) * NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (slot_valid[base + w]) begin
        if (hit < 0 && slot_key[base + w] == rq.key) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    case (rq.kind)
      REQ_GET: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.value_out = slot_value[base + hit];
        end
      end
      REQ_PUT: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.accepted = 1'b1;
          slot_value[base + hit] = rq.value;
        end else if (free_way >= 0) begin
          idx = base + free_way;
          r.accepted = 1'b1;
          slot_valid[idx] = 1'b1;
          slot_key[idx] = rq.key;
          slot_value[idx] = rq.value;
          live_count++;
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          idx = base + hit;
          r.found = 1'b1;
          r.key_out = slot_key[idx];
          r.value_out = slot_value[idx];
          slot_valid[idx] = 1'b0;
          slot_key[idx] = '0;
          slot_value[idx] = '0;
          if (live_count > 0) live_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = live_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic compare_result(rsp_word_t exp_w, rsp_word_t got_w);
    if (got_w.found !== exp_w.found) begin
      $error("found: expected %0d, got %0d", exp_w.found, got_w.found);
      mismatches++;
    end
    if (got_w.accepted !== exp_w.accepted) begin
      $error("accepted: expected %0d, got %0d", exp_w.accepted, got_w.accepted);
      mismatches++;
    end
    if (got_w.key_out !== exp_w.key_out) begin
      $error("key_out: expected %h, got %h", exp_w.key_out, got_w.key_out);
      mismatches++;
    end
    if (got_w.value_out !== exp_w.value_out) begin
      $error("value_out: expected %h, got %h", exp_w.value_out, got_w.value_out);
      mismatches++;
    end
    if (got_w.entry_count !== exp_w.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp_w.entry_count, got_w.entry_count);
      mismatches++;
    end
  endtask

  task automatic queue_req(logic [TYPE_W-1:0] kind, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] value, logic wait_idle);
    req_word_t rq;
    rq.kind = kind;
    rq.key = key;
    rq.value = value;
    rq.wait_idle = wait_idle;
    pending_q.push_back(rq);
    words_queued++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 70) return k;
    // same set as a pool key, different upper bits
    if (r < 85) return {32'($urandom), 15'($urandom_range(0, 15'h7fff)), k[16:0]} ^
                       {k[63:17], 17'd0};
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [TYPE_W-1:0] pick_kind(int profile);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return REQ_UNUSED;
    case (profile)
      PROFILE_FILL:  return (r < 75) ? REQ_PUT : (r < 90) ? REQ_GET : REQ_REMOVE;
      PROFILE_DRAIN: return (r < 20) ? REQ_PUT : (r < 45) ? REQ_GET : REQ_REMOVE;
      default:       return (r < 40) ? REQ_PUT : (r < 75) ? REQ_GET : REQ_REMOVE;
    endcase
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        req_bus.valid <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].wait_idle && expected_q.size() != 0)) begin
        req_bus.valid <= 1'b0;
      end else begin
        req_word_t rq;
        rq = pending_q.pop_front();
        req_bus.req_type  <= rq.kind;
        req_bus.req_key   <= rq.key;
        req_bus.req_value <= rq.value;
        req_bus.valid     <= 1'b1;
        send_gap = pick_gap();
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (!long_hold_done && words_taken >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD_CYCLES - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      rsp_bus.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_word_t got_w;
        got_w.found       = rsp_bus.found;
        got_w.accepted    = rsp_bus.accepted;
        got_w.key_out     = rsp_bus.key_out;
        got_w.value_out   = rsp_bus.value_out;
        got_w.entry_count = rsp_bus.entry_count;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          compare_result(expected_q.pop_front(), got_w);
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        req_word_t rq;
        rq.kind = req_bus.req_type;
        rq.key = req_bus.req_key;
        rq.value = req_bus.req_value;
        rq.wait_idle = 1'b0;
        expected_q.push_back(apply_request(rq));
        words_taken++;
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int profile;
    logic wait_first;
    rst_n = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_GET;
    req_bus.req_key = '0;
    req_bus.req_value = '0;
    rsp_bus.ready = 1'b0;
    mismatches = 0;
    words_queued = 0;
    words_taken = 0;
    send_gap = 0;
    stall_left = 0;
    req_taken = 1'b0;
    long_hold_done = 1'b0;
    live_count = 0;
    for (int i = 0; i < STORE_SIZE; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
    end
    // pool covers every set with five keys, so sets overflow
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][3:0] = 4'(i % NUM_SETS);
    end

    // directed: empty store, replace, full set, unused type, removes
    queue_req(REQ_GET,    64'h0, 32'h0, 1'b0);
    queue_req(REQ_REMOVE, 64'h0, 32'h0, 1'b0);
    queue_req(REQ_PUT,    64'h0, 32'hFFFF_FFFF, 1'b0);
    queue_req(REQ_GET,    64'h0, 32'h0, 1'b0);
    queue_req(REQ_PUT,    64'h0, 32'h0, 1'b0);
    queue_req(REQ_GET,    64'h0, 32'hFFFF_FFFF, 1'b0);
    queue_req(REQ_PUT,    64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(REQ_PUT,    64'h10, 32'h1234_5678, 1'b0);
    queue_req(REQ_PUT,    64'h20, 32'h8765_4321, 1'b0);
    queue_req(REQ_PUT,    64'hFFFF_FFFF_FFFF_FFF0, 32'hA5A5_A5A5, 1'b0);
    queue_req(REQ_PUT,    64'h30, 32'h5A5A_5A5A, 1'b0);
    queue_req(REQ_GET,    64'h30, 32'h0, 1'b0);
    queue_req(REQ_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_req(REQ_REMOVE, 64'h20, 32'h0, 1'b0);
    queue_req(REQ_PUT,    64'h30, 32'h5A5A_5A5A, 1'b0);
    queue_req(REQ_GET,    64'hFFFF_FFFF_FFFF_FFF0, 32'h0, 1'b0);
    queue_req(REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
    queue_req(REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
    queue_req(REQ_UNUSED, 64'h0, 32'h0, 1'b0);
    queue_req(REQ_REMOVE, 64'h0, 32'h0, 1'b0);
    queue_req(REQ_REMOVE, 64'h10, 32'h0, 1'b0);
    queue_req(REQ_REMOVE, 64'h30, 32'h0, 1'b0);
    queue_req(REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FFF0, 32'h0, 1'b0);
    queue_req(REQ_GET,    64'h30, 32'h0, 1'b0);

    // random phases that fill and drain the store
    for (int s = 0; s < SEGMENTS; s++) begin
      profile = (s == 0) ? PROFILE_FILL : $urandom_range(PROFILE_FILL, PROFILE_DRAIN);
      wait_first = (s % 3 == 0);
      for (int i = 0; i < SEGMENT_LEN; i++)
        queue_req(pick_kind(profile), pick_key(), pick_value(), wait_first && i == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (words_taken != words_queued) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
